// File: src/cvs_pkg.sv
package cvs_pkg;

	localparam int FRAMES_DEF = 32;
	localparam int FIW = 5;
	localparam int PIDW = 8;
	localparam int PGW = 16;

	typedef enum logic [1:0] {
		ACT_TOUCH = 2'd0,
		ACT_LOAD  = 2'd1,
		ACT_DROP  = 2'd2,
		ACT_FIND  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		K_NOP,
		K_TOUCH,
		K_LOAD,
		K_DROP,
		K_FIND
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t        kind;
		logic [FIW-1:0]   idx;
		logic [PIDW-1:0]  pid;
		logic [PGW-1:0]   page;
		logic             wr;
	} cmd_t;

	typedef struct packed {
		logic [PIDW-1:0]  owner;
		logic [PGW-1:0]   page;
		logic             used;
		logic             dirty;
		logic             rep;
	} ent_t;

endpackage

// File: src/clock_victim_select_unit.sv
// Load, ignored items and touches of empty frames answer on pop; touch reads the
// frame, then sets used and ORs in dirty; drop reads and checks every frame; find
// moves the hand past empty slots and checks valid frames until a victim is found
// or STEPS steps pass. Throughput is set by the back-end sequencer; it ends each
// item first; a 2-item queue lets the front keep accepting while a result waits.
// Async active-low reset clears valid bits, hand, queue and output register.
module clock_victim_select_unit import cvs_pkg::*; #(
	parameter int FRAMES = FRAMES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  logic [1:0]       action,
	input  logic [FIW-1:0]   frame_index,
	input  logic [PIDW-1:0]  process_id,
	input  logic [PGW-1:0]   virtual_page,
	input  logic             is_write,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output logic             victim_found,
	output logic [FIW-1:0]   victim_frame,
	output logic [PIDW-1:0]  victim_process,
	output logic [PGW-1:0]   victim_page,
	output logic             victim_dirty
);

	logic q_valid;
	logic q_pop;
	cmd_t q_cmd;

	cvs_front #(.FRAMES(FRAMES)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.action       (action),
		.frame_index  (frame_index),
		.process_id   (process_id),
		.virtual_page (virtual_page),
		.is_write     (is_write),
		.q_valid      (q_valid),
		.q_cmd        (q_cmd),
		.q_pop        (q_pop)
	);

	cvs_back #(.FRAMES(FRAMES)) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_cmd          (q_cmd),
		.q_pop          (q_pop),
		.rsp_valid      (rsp_valid),
		.rsp_ready      (rsp_ready),
		.victim_found   (victim_found),
		.victim_frame   (victim_frame),
		.victim_process (victim_process),
		.victim_page    (victim_page),
		.victim_dirty   (victim_dirty)
	);

endmodule

// File: src/cvs_front.sv
module cvs_front import cvs_pkg::*; #(
	parameter int FRAMES = FRAMES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  logic [1:0]       action,
	input  logic [FIW-1:0]   frame_index,
	input  logic [PIDW-1:0]  process_id,
	input  logic [PGW-1:0]   virtual_page,
	input  logic             is_write,
	output logic             q_valid,
	output cmd_t             q_cmd,
	input  logic             q_pop
);

	cmd_t       slot_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;
	cmd_t       cmd;
	logic       idx_ok;
	logic       push;

	assign idx_ok = int'(frame_index) < FRAMES;

	always_comb begin
		cmd.idx  = frame_index;
		cmd.pid  = process_id;
		cmd.page = virtual_page;
		cmd.wr   = is_write;
		case (action_t'(action))
			ACT_TOUCH: cmd.kind = idx_ok ? K_TOUCH : K_NOP;
			ACT_LOAD:  cmd.kind = idx_ok ? K_LOAD : K_NOP;
			ACT_DROP:  cmd.kind = K_DROP;
			ACT_FIND:  cmd.kind = K_FIND;
			default:   cmd.kind = K_NOP;
		endcase
	end

	assign req_ready = cnt_q != 2'd2;
	assign push      = req_valid && req_ready;
	assign q_valid   = cnt_q != 2'd0;
	assign q_cmd     = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wptr_q] <= cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push)
				wptr_q <= !wptr_q;
			if (q_pop)
				rptr_q <= !rptr_q;
			case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: src/cvs_back.sv
module cvs_back import cvs_pkg::*; #(
	parameter int FRAMES = FRAMES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  cmd_t             q_cmd,
	output logic             q_pop,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output logic             victim_found,
	output logic [FIW-1:0]   victim_frame,
	output logic [PIDW-1:0]  victim_process,
	output logic [PGW-1:0]   victim_page,
	output logic             victim_dirty
);

	localparam int IW    = $clog2(FRAMES);
	localparam int STEPS = 3 * FRAMES;
	localparam int SW    = $clog2(STEPS + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_TOUCH,
		S_DROP_RD,
		S_DROP_CHK,
		S_FIND_RD,
		S_FIND_CHK
	} state_t;

	state_t          state_q;
	cmd_t            cmd_q;
	logic [FRAMES-1:0] valid_q;
	logic [IW-1:0]   hand_q;
	logic [IW-1:0]   cnt_q;
	logic [SW-1:0]   steps_q;
	logic            rsp_valid_q;
	logic            found_q;
	logic [FIW-1:0]  frame_q;
	logic [PIDW-1:0] proc_q;
	logic [PGW-1:0]  page_q;
	logic            dirty_q;

	ent_t            mem [FRAMES];
	ent_t            rd_q;
	logic            mem_we;
	logic            mem_re;
	logic [IW-1:0]   mem_waddr;
	logic [IW-1:0]   mem_raddr;
	ent_t            mem_wdata;

	logic [IW-1:0]   pop_addr;
	logic [IW-1:0]   hand_nx;
	logic            slot_free;

	assign slot_free = !rsp_valid_q || rsp_ready;
	assign q_pop     = (state_q == S_IDLE) && q_valid && slot_free;
	assign pop_addr  = IW'(q_cmd.idx);
	assign hand_nx   = (hand_q == IW'(FRAMES - 1)) ? '0 : hand_q + 1'b1;

	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = hand_q;
		mem_raddr = hand_q;
		mem_wdata = rd_q;
		case (state_q)
			S_IDLE: begin
				if (q_pop) begin
					if (q_cmd.kind == K_TOUCH) begin
						mem_re    = valid_q[pop_addr];
						mem_raddr = pop_addr;
					end else if (q_cmd.kind == K_LOAD) begin
						mem_we          = 1'b1;
						mem_waddr       = pop_addr;
						mem_wdata.owner = q_cmd.pid;
						mem_wdata.page  = q_cmd.page;
						mem_wdata.used  = 1'b0;
						mem_wdata.dirty = 1'b0;
						mem_wdata.rep   = 1'b1;
					end
				end
			end
			S_TOUCH: begin
				mem_we          = 1'b1;
				mem_waddr       = IW'(cmd_q.idx);
				mem_wdata.used  = 1'b1;
				mem_wdata.dirty = rd_q.dirty || cmd_q.wr;
			end
			S_DROP_RD: begin
				mem_re    = 1'b1;
				mem_raddr = cnt_q;
			end
			S_FIND_RD: begin
				mem_re = valid_q[hand_q] && (steps_q != SW'(STEPS));
			end
			S_FIND_CHK: begin
				if (rd_q.used) begin
					mem_we         = 1'b1;
					mem_wdata.used = 1'b0;
				end else if (rd_q.dirty && rd_q.rep) begin
					mem_we        = 1'b1;
					mem_wdata.rep = 1'b0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		if (mem_re)
			rd_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			valid_q     <= '0;
			hand_q      <= '0;
			cnt_q       <= '0;
			steps_q     <= '0;
			rsp_valid_q <= 1'b0;
			found_q     <= 1'b0;
			frame_q     <= '0;
			proc_q      <= '0;
			page_q      <= '0;
			dirty_q     <= 1'b0;
			cmd_q       <= '0;
		end else begin
			if (rsp_valid_q && rsp_ready)
				rsp_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						cmd_q   <= q_cmd;
						found_q <= 1'b0;
						frame_q <= '0;
						proc_q  <= '0;
						page_q  <= '0;
						dirty_q <= 1'b0;
						case (q_cmd.kind)
							K_TOUCH: begin
								if (valid_q[pop_addr])
									state_q <= S_TOUCH;
								else
									rsp_valid_q <= 1'b1;
							end
							K_LOAD: begin
								valid_q[pop_addr] <= 1'b1;
								rsp_valid_q       <= 1'b1;
							end
							K_DROP: begin
								cnt_q   <= '0;
								state_q <= S_DROP_RD;
							end
							K_FIND: begin
								steps_q <= '0;
								state_q <= S_FIND_RD;
							end
							default: rsp_valid_q <= 1'b1;
						endcase
					end
				end
				S_TOUCH: begin
					rsp_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_DROP_RD: state_q <= S_DROP_CHK;
				S_DROP_CHK: begin
					if (valid_q[cnt_q] && rd_q.owner == cmd_q.pid)
						valid_q[cnt_q] <= 1'b0;
					if (cnt_q == IW'(FRAMES - 1)) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= S_DROP_RD;
					end
				end
				S_FIND_RD: begin
					if (steps_q == SW'(STEPS)) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else if (!valid_q[hand_q]) begin
						hand_q  <= hand_nx;
						steps_q <= steps_q + 1'b1;
					end else begin
						state_q <= S_FIND_CHK;
					end
				end
				S_FIND_CHK: begin
					hand_q <= hand_nx;
					if (rd_q.used || (rd_q.dirty && rd_q.rep)) begin
						steps_q <= steps_q + 1'b1;
						state_q <= S_FIND_RD;
					end else begin
						found_q     <= 1'b1;
						frame_q     <= FIW'(hand_q);
						proc_q      <= rd_q.owner;
						page_q      <= rd_q.page;
						dirty_q     <= rd_q.dirty;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign victim_found   = found_q;
	assign victim_frame   = frame_q;
	assign victim_process = proc_q;
	assign victim_page    = page_q;
	assign victim_dirty   = dirty_q;

endmodule
